### hdl/bse_pkg.sv
// bse_pkg: shared constants, state codes and controller/datapath types
// for the bubble sort engine; no dependencies
`default_nettype none

package bse_pkg;

	localparam int MAX_ELEMENTS = 64;
	localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
	localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
	localparam int DATA_W       = 32;

	// controller states
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_LOAD0 = 3'd1;
	localparam logic [2:0] S_LOAD1 = 3'd2;
	localparam logic [2:0] S_STEP  = 3'd3;
	localparam logic [2:0] S_FLUSH = 3'd4;
	localparam logic [2:0] S_ORD   = 3'd5;
	localparam logic [2:0] S_OLD   = 3'd6;

	// store write data select
	localparam logic [1:0] WSEL_IN    = 2'd0;
	localparam logic [1:0] WSEL_KEEP  = 2'd1;
	localparam logic [1:0] WSEL_CARRY = 2'd2;

	typedef struct packed {
		logic              wr_en;
		logic [1:0]        wr_sel;
		logic [ADDR_W-1:0] wr_addr;
		logic [ADDR_W-1:0] rd_addr;
		logic              carry_ld;
		logic              step;
		logic              asc_ld;
		logic              out_ld;
		logic              out_last;
		logic              out_ovf;
	} bse_cmd_t;

	typedef struct packed {
		logic [2:0]        state;
		logic [CNT_W-1:0]  cnt;
		logic [ADDR_W-1:0] pair;
		logic [ADDR_W-1:0] top;
	} bse_stat_t;

endpackage

`default_nettype wire

### hdl/bse_datapath.sv
// bse_datapath: element store, compare-swap unit with carried element,
// order register and output register; depends on bse_pkg
`default_nettype none

module bse_datapath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire bse_pkg::bse_cmd_t             cmd,
	input  wire logic [bse_pkg::DATA_W-1:0]    in_value,
	input  wire logic                          cfg_wen,
	input  wire logic                          cfg_wdata,
	output logic      [bse_pkg::DATA_W-1:0]    out_value,
	output logic                               out_last,
	output logic                               out_ovf
);

	logic [bse_pkg::DATA_W-1:0] mem_q [bse_pkg::MAX_ELEMENTS];
	logic [bse_pkg::DATA_W-1:0] rd_q;
	logic [bse_pkg::DATA_W-1:0] carry_q;
	logic [bse_pkg::DATA_W-1:0] keep;
	logic [bse_pkg::DATA_W-1:0] other;
	logic [bse_pkg::DATA_W-1:0] wr_data;
	logic                       asc_cfg_q;
	logic                       asc_q;
	logic                       swap;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			asc_cfg_q <= 1'b1;
		end else if (cfg_wen) begin
			asc_cfg_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.asc_ld) begin
			asc_q <= asc_cfg_q;
		end
	end

	// strict compare keeps equal values in arrival order
	always_comb begin
		if (asc_q) begin
			swap = $signed(carry_q) > $signed(rd_q);
		end else begin
			swap = $signed(rd_q) > $signed(carry_q);
		end
		keep  = swap ? rd_q : carry_q;
		other = swap ? carry_q : rd_q;
	end

	always_comb begin
		unique case (cmd.wr_sel)
			bse_pkg::WSEL_IN:    wr_data = in_value;
			bse_pkg::WSEL_KEEP:  wr_data = keep;
			bse_pkg::WSEL_CARRY: wr_data = carry_q;
			default:             wr_data = in_value;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem_q[cmd.wr_addr] <= wr_data;
		end
		rd_q <= mem_q[cmd.rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.carry_ld) begin
			carry_q <= rd_q;
		end else if (cmd.step) begin
			carry_q <= other;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			out_value <= rd_q;
			out_last  <= cmd.out_last;
			out_ovf   <= cmd.out_ovf;
		end
	end

endmodule

`default_nettype wire

### hdl/bse_ctrl.sv
// bse_ctrl: state machine for collect, bubble passes and drain; drives the
// datapath commands and the stream handshakes; depends on bse_pkg
`default_nettype none

module bse_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic               s_tlast,
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output bse_pkg::bse_cmd_t       cmd,
	output bse_pkg::bse_stat_t      stat
);

	logic [2:0]                   state_q, state_d;
	logic [bse_pkg::CNT_W-1:0]    cnt_q, cnt_d;
	logic                         drop_q, drop_d;
	logic [bse_pkg::ADDR_W-1:0]   j_q, j_d;
	logic [bse_pkg::ADDR_W-1:0]   e_q, e_d;
	logic [bse_pkg::ADDR_W-1:0]   k_q, k_d;
	logic                         out_valid_q, out_valid_d;
	logic                         k_last;

	assign k_last = (k_q == bse_pkg::ADDR_W'(cnt_q - bse_pkg::CNT_W'(1)));

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		drop_d   = drop_q;
		j_d      = j_q;
		e_d      = e_q;
		k_d      = k_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			bse_pkg::S_IDLE: begin
				s_tready    = 1'b1;
				cmd.wr_sel  = bse_pkg::WSEL_IN;
				cmd.wr_addr = cnt_q[bse_pkg::ADDR_W-1:0];
				if (s_tvalid) begin
					if (cnt_q < bse_pkg::CNT_W'(bse_pkg::MAX_ELEMENTS)) begin
						cmd.wr_en = 1'b1;
						cnt_d     = cnt_q + bse_pkg::CNT_W'(1);
					end else begin
						drop_d = 1'b1;
					end
					if (s_tlast) begin
						cmd.asc_ld = 1'b1;
						k_d        = '0;
						if (cnt_d <= bse_pkg::CNT_W'(1)) begin
							state_d = bse_pkg::S_ORD;
						end else begin
							e_d     = bse_pkg::ADDR_W'(cnt_d - bse_pkg::CNT_W'(1));
							state_d = bse_pkg::S_LOAD0;
						end
					end
				end
			end
			bse_pkg::S_LOAD0: begin
				cmd.rd_addr = '0;
				state_d     = bse_pkg::S_LOAD1;
			end
			bse_pkg::S_LOAD1: begin
				cmd.rd_addr  = bse_pkg::ADDR_W'(1);
				cmd.carry_ld = 1'b1;
				j_d          = '0;
				state_d      = bse_pkg::S_STEP;
			end
			bse_pkg::S_STEP: begin
				// read data holds element j+1, carry holds element j
				cmd.step    = 1'b1;
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = bse_pkg::WSEL_KEEP;
				cmd.wr_addr = j_q;
				cmd.rd_addr = j_q + bse_pkg::ADDR_W'(2);
				if (j_q + bse_pkg::ADDR_W'(1) == e_q) begin
					state_d = bse_pkg::S_FLUSH;
				end else begin
					j_d = j_q + bse_pkg::ADDR_W'(1);
				end
			end
			bse_pkg::S_FLUSH: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = bse_pkg::WSEL_CARRY;
				cmd.wr_addr = e_q;
				e_d         = e_q - bse_pkg::ADDR_W'(1);
				if (e_q == bse_pkg::ADDR_W'(1)) begin
					k_d     = '0;
					state_d = bse_pkg::S_ORD;
				end else begin
					state_d = bse_pkg::S_LOAD0;
				end
			end
			bse_pkg::S_ORD: begin
				cmd.rd_addr = k_q;
				state_d     = bse_pkg::S_OLD;
			end
			bse_pkg::S_OLD: begin
				cmd.rd_addr = k_q;
				if (!out_valid_q || m_tready) begin
					cmd.out_ld   = 1'b1;
					cmd.out_last = k_last;
					cmd.out_ovf  = drop_q;
					cmd.rd_addr  = k_q + bse_pkg::ADDR_W'(1);
					k_d          = k_q + bse_pkg::ADDR_W'(1);
					if (k_last) begin
						cnt_d   = '0;
						drop_d  = 1'b0;
						state_d = bse_pkg::S_IDLE;
					end
				end
			end
			default: begin
				state_d = bse_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		if (cmd.out_ld) begin
			out_valid_d = 1'b1;
		end else if (m_tready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bse_pkg::S_IDLE;
			cnt_q       <= '0;
			drop_q      <= 1'b0;
			j_q         <= '0;
			e_q         <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			drop_q      <= drop_d;
			j_q         <= j_d;
			e_q         <= e_d;
			k_q         <= k_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign stat.state = state_q;
	assign stat.cnt   = cnt_q;
	assign stat.pair  = j_q;
	assign stat.top   = e_q;

endmodule

`default_nettype wire

### hdl/bubble_sort_engine_core.sv
// bubble_sort_engine_core: top level joining bse_ctrl and bse_datapath
// depends on bse_pkg, bse_ctrl, bse_datapath
//
// usage
//  - slave stream takes one signed 32-bit element per beat, tlast on the
//    final element of a list; up to 64 elements are stored, later ones are
//    dropped and every result of that list then has tuser (overflow) set
//  - cfg_wen/cfg_wdata write the order bit (1 ascending, 0 descending);
//    the bit is sampled when the last element of a list is taken
//  - collect: one beat per cycle; s_tready is low from the last beat until
//    the final result of that list has been loaded into the output register
//  - sort: each pass over the top index e compares every pair below e (one
//    store read and one store write per compare-swap), then writes the carried
//    element back at e; a one-element list skips it
//  - drain: one result per cycle unless the master stalls, after a start
//    read; single registered store read port; m_tlast on the final element
//  - a stalled master side holds the output register and the drain waits;
//    the next list is collected while the last result is still pending
//  - reset: order ascending, store contents undefined, no pending results
`default_nettype none

module bubble_sort_engine_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [31:0] value
	input  wire logic        s_tlast,   // last
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [31:0] m_tdata,   // [31:0] sorted_value
	output logic             m_tlast,   // last_out
	output logic             m_tuser,   // [0] overflow
	input  wire logic        cfg_wen,
	input  wire logic        cfg_wdata
);

	bse_pkg::bse_cmd_t  cmd;
	bse_pkg::bse_stat_t stat;

	bse_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.stat     (stat)
	);

	bse_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_value  (s_tdata),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.out_value (m_tdata),
		.out_last  (m_tlast),
		.out_ovf   (m_tuser)
	);

	// stored count never passes the store depth
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.cnt <= bse_pkg::CNT_W'(bse_pkg::MAX_ELEMENTS))
		else $error("element count beyond store depth");

	// compare-swap index stays below the top of the current pass
	a_pair_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.state == bse_pkg::S_STEP |-> stat.pair < stat.top)
		else $error("pair index at or past pass top");

	// a new result appears only out of the drain state
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(stat.state) == bse_pkg::S_OLD)
		else $error("result loaded outside drain");

	// a list of two or more elements is sorted before it is drained
	a_sort_first: assert property (@(posedge clk) disable iff (!arst_n)
		stat.state == bse_pkg::S_ORD && $past(stat.state) != bse_pkg::S_IDLE
		|-> $past(stat.state) == bse_pkg::S_FLUSH)
		else $error("drain started without finishing sort");

endmodule

`default_nettype wire
